FILE: sv/npe_pkg.sv
// Package of the MIDI note pairing engine: sizes, message codes, result kinds,
// controller states and the request and result records.
// No dependencies; every other file of the block but npe_ram imports it.
`default_nettype none

package npe_pkg;

   localparam int STARTS_PER_KEY = 4;
   localparam int CHANNEL_COUNT  = 16;
   localparam int PITCH_COUNT    = 128;

   localparam int KEY_COUNT   = CHANNEL_COUNT * PITCH_COUNT;
   localparam int CHAN_W      = $clog2(CHANNEL_COUNT);
   localparam int PITCH_W     = $clog2(PITCH_COUNT);
   localparam int KEY_W       = CHAN_W + PITCH_W;
   localparam int SLOT_W      = (STARTS_PER_KEY > 1) ? $clog2(STARTS_PER_KEY) : 1;
   localparam int SUM_W       = SLOT_W + 1;
   localparam int CNT_W       = $clog2(STARTS_PER_KEY + 1);
   localparam int META_W      = CNT_W + SLOT_W;
   localparam int STORE_DEPTH = KEY_COUNT * STARTS_PER_KEY;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CHOPEN_W    = $clog2(PITCH_COUNT * STARTS_PER_KEY + 1);
   localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

   localparam int FRAME_W  = 32;
   localparam int STATUS_W = 8;
   localparam int DATA_W   = 7;
   localparam int STORE_W  = DATA_W + FRAME_W;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 104;

   // message type nibbles
   localparam logic [3:0] MSG_NOTE_OFF      = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON       = 4'h9;
   localparam logic [3:0] MSG_CONTROL       = 4'hB;
   localparam logic [3:0] MSG_CHAN_PRESSURE = 4'hD;
   localparam logic [3:0] MSG_PITCH_BEND    = 4'hE;
   localparam logic [3:0] MSG_SYSTEM        = 4'hF;

   localparam logic [STATUS_W-1:0] STATUS_FIRST  = 8'h80;
   localparam logic [DATA_W-1:0]   CC_BRIGHTNESS = 7'd74;

   typedef enum logic [1:0] {
      KIND_NOTE        = 2'd0,
      KIND_EXPR        = 2'd1,
      KIND_DROPPED     = 2'd2,
      KIND_FLUSH_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_NOTE_ON,
      OP_NOTE_OFF,
      OP_EXPR
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                flush;
      logic [FRAME_W-1:0]  frame;
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_one;
      logic [DATA_W-1:0]   data_two;
   } request_type;

   typedef struct packed {
      kind_type            kind;
      logic [FRAME_W-1:0]  start_frame;
      logic [FRAME_W-1:0]  end_frame;
      logic [DATA_W-1:0]   velocity;
      logic [PITCH_W-1:0]  pitch;
      logic [CHAN_W-1:0]   channel;
      logic [STATUS_W-1:0] expr_status;
      logic [DATA_W-1:0]   expr_data_one;
      logic [DATA_W-1:0]   expr_data_two;
   } result_type;

   // word address of one start slot of one key
   function automatic logic [STORE_AW-1:0] store_addr(input logic [KEY_W-1:0]  key,
                                                      input logic [SLOT_W-1:0] slot);
      store_addr = STORE_AW'(key) * STORE_AW'(STARTS_PER_KEY) + STORE_AW'(slot);
   endfunction

endpackage

`default_nettype wire

FILE: sv/npe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module npe_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/npe_seq.sv
// Pairing sequencer: key queue metadata RAM, start slot RAM, per channel open
// counts, the flush scan and the frame limit register.
// Depends on npe_pkg and npe_ram.
`default_nettype none

module npe_seq
   import npe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  request_type        req,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [FRAME_W-1:0] csr_wdata,
   input  logic               res_free,
   output logic               res_valid,
   output result_type         res
);

   state_type state_ff, state_in;
   op_type    op_ff, op_req;

   logic [FRAME_W-1:0]  frame_limit_ff;
   request_type         ev_ff;
   logic [KEY_W-1:0]    clr_addr_ff;
   logic [CHOPEN_W-1:0] chan_open_ff [CHANNEL_COUNT];
   logic [TOTAL_W-1:0]  total_ff;
   logic [KEY_W-1:0]    flush_ptr_ff;
   logic [KEY_W-1:0]    scan_addr_ff;
   logic [KEY_W-1:0]    chk_key_ff;
   logic                chk_vld_ff;
   result_type          res_ff, res_in;
   logic                from_store_ff, from_store_in;

   logic                meta_wr_en, meta_rd_en;
   logic [KEY_W-1:0]    meta_wr_addr, meta_rd_addr;
   logic [META_W-1:0]   meta_wr_data, meta_rd_data;
   logic                store_wr_en, store_rd_en;
   logic [STORE_AW-1:0] store_wr_addr, store_rd_addr;
   logic [STORE_W-1:0]  store_wr_data, store_rd_data;

   logic                accept, late, flush_empty;
   logic [KEY_W-1:0]    req_key, ev_key, pop_key;
   logic [CHAN_W-1:0]   ev_chan, cnt_chan;
   logic [3:0]          req_msg;
   logic [SLOT_W-1:0]   cur_head, head_next, push_slot;
   logic [CNT_W-1:0]    cur_cnt;
   logic [SUM_W-1:0]    slot_sum;
   logic                full, found, push, drop, pop_off, pop_scan, pop, expr_hit;

   // ---------------------------------------------------------------- decode
   assign accept      = req_valid && req_ready;
   assign req_key     = {req.status[CHAN_W-1:0], req.data_one};
   assign req_msg     = req.status[STATUS_W-1:STATUS_W-4];
   assign late        = req.frame >= frame_limit_ff;
   assign flush_empty = accept && req.flush && (total_ff == '0);

   always_comb begin
      priority if (late || req.status < STATUS_FIRST || req_msg == MSG_SYSTEM) begin
         op_req = OP_NONE;
      end else if (req_msg == MSG_NOTE_ON && req.data_two != '0) begin
         op_req = OP_NOTE_ON;
      end else if (req_msg == MSG_NOTE_OFF || req_msg == MSG_NOTE_ON) begin
         op_req = OP_NOTE_OFF;
      end else if (req_msg == MSG_PITCH_BEND || req_msg == MSG_CHAN_PRESSURE ||
                   (req_msg == MSG_CONTROL && req.data_one == CC_BRIGHTNESS)) begin
         op_req = OP_EXPR;
      end else begin
         op_req = OP_NONE;
      end
   end

   assign ev_key  = {ev_ff.status[CHAN_W-1:0], ev_ff.data_one};
   assign ev_chan = ev_ff.status[CHAN_W-1:0];

   assign cur_head  = meta_rd_data[SLOT_W-1:0];
   assign cur_cnt   = meta_rd_data[META_W-1:SLOT_W];
   assign full      = cur_cnt >= CNT_W'(STARTS_PER_KEY);
   assign head_next = (cur_head == SLOT_W'(STARTS_PER_KEY - 1)) ? '0 : cur_head + 1'b1;
   assign slot_sum  = {1'b0, cur_head} + SUM_W'(cur_cnt);
   assign push_slot = (slot_sum >= SUM_W'(STARTS_PER_KEY))
                    ? SLOT_W'(slot_sum - SUM_W'(STARTS_PER_KEY)) : SLOT_W'(slot_sum);

   assign found    = chk_vld_ff && (cur_cnt != '0);
   assign cnt_chan = (state_ff == ST_SCAN) ? chk_key_ff[KEY_W-1:PITCH_W] : ev_chan;

   assign push     = (state_ff == ST_LOOKUP) && (op_ff == OP_NOTE_ON) && !full;
   assign drop     = (state_ff == ST_LOOKUP) && (op_ff == OP_NOTE_ON) && full;
   assign pop_off  = (state_ff == ST_LOOKUP) && (op_ff == OP_NOTE_OFF) && (cur_cnt != '0);
   assign expr_hit = (state_ff == ST_LOOKUP) && (op_ff == OP_EXPR) &&
                     (chan_open_ff[cnt_chan] != '0);
   assign pop_scan = (state_ff == ST_SCAN) && found;
   assign pop      = pop_off || pop_scan;
   assign pop_key  = pop_scan ? chk_key_ff : ev_key;

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == KEY_W'(KEY_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (!req.flush) begin
                  state_in = ST_LOOKUP;
               end else if (flush_empty) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = (drop || pop_off || expr_hit) ? ST_EMIT : ST_IDLE;
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------- outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;
      res_valid = (state_ff == ST_EMIT);

      meta_wr_en   = (state_ff == ST_CLEAR) || push || pop;
      meta_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : pop_key;
      if (state_ff == ST_CLEAR) begin
         meta_wr_data = '0;
      end else if (push) begin
         meta_wr_data = {cur_cnt + 1'b1, cur_head};
      end else begin
         meta_wr_data = {cur_cnt - 1'b1, head_next};
      end
      meta_rd_en   = (accept && !req.flush) || ((state_ff == ST_SCAN) && !found);
      meta_rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : req_key;

      store_wr_en   = push;
      store_wr_addr = store_addr(ev_key, push_slot);
      store_wr_data = {ev_ff.data_two, ev_ff.frame};
      store_rd_en   = pop;
      store_rd_addr = store_addr(pop_key, cur_head);

      res = res_ff;
      if (from_store_ff) begin
         res.start_frame = store_rd_data[FRAME_W-1:0];
         res.velocity    = store_rd_data[STORE_W-1:FRAME_W];
      end
   end

   // ------------------------------------------------------- result staging
   always_comb begin
      res_in        = res_ff;
      from_store_in = from_store_ff;
      priority if (flush_empty) begin
         res_in        = '0;
         res_in.kind   = KIND_FLUSH_EMPTY;
         from_store_in = 1'b0;
      end else if (drop) begin
         res_in             = '0;
         res_in.kind        = KIND_DROPPED;
         res_in.start_frame = ev_ff.frame;
         res_in.velocity    = ev_ff.data_two;
         res_in.pitch       = ev_ff.data_one;
         res_in.channel     = ev_chan;
         from_store_in      = 1'b0;
      end else if (pop) begin
         // start frame and velocity come from the slot read now
         res_in           = '0;
         res_in.kind      = KIND_NOTE;
         res_in.end_frame = pop_scan ? frame_limit_ff : ev_ff.frame;
         res_in.pitch     = pop_key[PITCH_W-1:0];
         res_in.channel   = pop_key[KEY_W-1:PITCH_W];
         from_store_in    = 1'b1;
      end else if (expr_hit) begin
         res_in               = '0;
         res_in.kind          = KIND_EXPR;
         res_in.start_frame   = ev_ff.frame;
         res_in.channel       = ev_chan;
         res_in.expr_status   = ev_ff.status;
         res_in.expr_data_one = ev_ff.data_one;
         res_in.expr_data_two = ev_ff.data_two;
         from_store_in        = 1'b0;
      end
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         frame_limit_ff <= '1;
         clr_addr_ff    <= '0;
         total_ff       <= '0;
         flush_ptr_ff   <= '0;
         chk_vld_ff     <= 1'b0;
         op_ff          <= OP_NONE;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            chan_open_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            frame_limit_ff <= csr_wdata;
         end
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (accept) begin
            op_ff <= op_req;
         end
         if (push) begin
            chan_open_ff[cnt_chan] <= chan_open_ff[cnt_chan] + 1'b1;
            total_ff               <= total_ff + 1'b1;
         end else if (pop) begin
            chan_open_ff[cnt_chan] <= chan_open_ff[cnt_chan] - 1'b1;
            total_ff               <= total_ff - 1'b1;
         end
         if (flush_empty) begin
            flush_ptr_ff <= '0;
         end else if (pop_scan) begin
            flush_ptr_ff <= chk_key_ff;
         end
         if (accept) begin
            chk_vld_ff <= 1'b0;
         end else if ((state_ff == ST_SCAN) && !found) begin
            chk_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff        <= res_in;
      from_store_ff <= from_store_in;
      if (accept) begin
         ev_ff        <= req;
         scan_addr_ff <= flush_ptr_ff;
      end else if ((state_ff == ST_SCAN) && !found) begin
         // advance the scan one key per cycle, wrapping round all keys
         scan_addr_ff <= scan_addr_ff + 1'b1;
         chk_key_ff   <= scan_addr_ff;
      end
   end

   // ---------------------------------------------------------------- stores
   npe_ram #(
      .WIDTH (META_W),
      .DEPTH (KEY_COUNT)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_data)
   );

   npe_ram #(
      .WIDTH (STORE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

endmodule

`default_nettype wire

FILE: sv/npe_rsp_stage.sv
// Result output register: holds one result word towards the receiver and
// packs it onto rsp_tdata and rsp_tuser. Depends on npe_pkg.
`default_nettype none

module npe_rsp_stage
   import npe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   input  result_type             res,
   output logic                   res_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser
);

   logic                   valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] data_ff;
   kind_type               kind_ff;
   logic                   load;

   assign res_free = !valid_ff || rsp_tready;
   assign load     = res_valid && res_free;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= res.kind;
         data_ff <= {res.expr_data_two, res.expr_data_one, res.expr_status, res.channel,
                     res.pitch, res.velocity, res.end_frame, res.start_frame};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;

endmodule

`default_nettype wire

FILE: sv/midi_note_pairing_engine_unit.sv
// MIDI note pairing engine, top level.
// Depends on npe_pkg, npe_seq (with npe_ram) and npe_rsp_stage.
//
// Usage:
//   req_* carries one word per MIDI event or flush step; rsp_* returns zero or
//   one result word per request word; csr_* writes the frame limit (always
//   ready, write only while no request is in progress).
//   A note-on that queues reads the key's queue metadata on acceptance and
//   writes it back in the next cycle. A note-off reads the metadata, then the
//   start slot, then loads the result register; a kept expression event or a
//   dropped note-on loads the result register straight after the metadata
//   read. A flush step scans the metadata RAM one key per cycle from the last
//   flushed key to the next key holding a start; with nothing open it goes
//   straight to its result word. Requests are handled one at a time.
//   After reset a clearing pass writes all KEY_COUNT (2048) metadata entries,
//   during which req_tready stays low; the frame limit returns to all ones.
//   The start slot RAM is not cleared.
//   The result register holds its word while rsp_tready is low; the block may
//   accept the next request meanwhile and waits only when a second result is
//   ready before the first is taken.
`default_nettype none

module midi_note_pairing_engine_unit
   import npe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] event_frame, [39:32] status_byte, [46:40] data_one,
   // [53:47] data_two, [55:54] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] operation
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] start_frame, [63:32] end_frame, [70:64] note_velocity,
   // [77:71] note_pitch, [81:78] note_channel, [89:82] expr_status,
   // [96:90] expr_data_one, [103:97] expr_data_two
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]             rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [FRAME_W-1:0]     csr_wdata
);

   request_type req;
   result_type  res;
   logic        res_valid, res_free;

   assign req.flush    = req_tuser;
   assign req.frame    = req_tdata[31:0];
   assign req.status   = req_tdata[39:32];
   assign req.data_one = req_tdata[46:40];
   assign req.data_two = req_tdata[53:47];

   npe_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res       (res)
   );

   npe_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .res_free   (res_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: sv/npe_checker.sv
// Port level checks of the MIDI note pairing engine, bound to its top level.
// Depends on npe_pkg.
`default_nettype none

module npe_checker
   import npe_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // reset starts the clearing pass with nothing to deliver
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("ready or result valid right after reset");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   a_flush_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_FLUSH_EMPTY |-> rsp_tdata == '0)
      else $error("empty flush result carries data");

   a_no_end_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EXPR || rsp_tuser == KIND_DROPPED)
      |-> rsp_tdata[63:32] == '0)
      else $error("end frame set on expression or dropped note-on");

endmodule

bind midi_note_pairing_engine_unit npe_checker u_npe_checker (.*);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking bench for midi_note_pairing_engine_unit: drives MIDI event and flush words,
// predicts each result word in a behavioural pairing model and checks it on arrival.
// Depends on npe_pkg and the engine RTL only.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import npe_pkg::*;

   localparam int CYCLE_LIMIT = 5_000_000;
   localparam logic [3:0] MSG_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] MSG_PROGRAM       = 4'hC;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [FRAME_W-1:0]     csr_wdata  = '0;

   // pairing model state
   logic [FRAME_W-1:0] slot_frame    [STORE_DEPTH];
   logic [DATA_W-1:0]  slot_velocity [STORE_DEPTH];
   int unsigned        key_head      [KEY_COUNT];
   int unsigned        key_count     [KEY_COUNT];
   int unsigned        chan_open     [CHANNEL_COUNT];
   int unsigned        scan_key      = 0;
   int unsigned        open_starts   = 0;
   logic [FRAME_W-1:0] limit_now     = '1;

   result_type awaited_results [$];
   int         mismatch_count   = 0;
   int         cycle_count      = 0;
   int         sent_items       = 0;
   int         send_idle_pct    = 17;
   int         sink_idle_pct    = 17;
   int         sink_hold_cycles = 0;

   midi_note_pairing_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // result sink: random stalls, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            sink_hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   function automatic request_type midi_word(input logic [FRAME_W-1:0] frame,
                                             input logic [STATUS_W-1:0] status,
                                             input logic [DATA_W-1:0] d1,
                                             input logic [DATA_W-1:0] d2);
      request_type r;
      r.flush    = 1'b0;
      r.frame    = frame;
      r.status   = status;
      r.data_one = d1;
      r.data_two = d2;
      return r;
   endfunction

   // the payload of a flush word is ignored, so fill it with noise
   function automatic request_type flush_word();
      request_type r;
      r.flush    = 1'b1;
      r.frame    = $urandom;
      r.status   = STATUS_W'($urandom_range(255));
      r.data_one = DATA_W'($urandom_range(127));
      r.data_two = DATA_W'($urandom_range(127));
      return r;
   endfunction

   function automatic void take_oldest(input int unsigned key,
                                       output logic [FRAME_W-1:0] frame,
                                       output logic [DATA_W-1:0] vel);
      int unsigned idx;
      idx = key * STARTS_PER_KEY + key_head[key];
      frame = slot_frame[idx];
      vel = slot_velocity[idx];
      key_head[key] = (key_head[key] + 1) % STARTS_PER_KEY;
      key_count[key]--;
      chan_open[key / PITCH_COUNT]--;
      open_starts--;
   endfunction

   // advance the model by one accepted word; returns 1 when a result word follows
   function automatic bit pair_event(input request_type r, output result_type res);
      logic [3:0]         msg;
      logic [CHAN_W-1:0]  chan;
      int unsigned        key;
      int unsigned        k;
      int unsigned        slot;
      int unsigned        i;
      logic [FRAME_W-1:0] frm;
      logic [DATA_W-1:0]  vel;
      res = '0;
      msg = r.status[7:4];
      chan = r.status[3:0];
      key = 32'({chan, r.data_one});
      if (r.flush) begin
         for (i = 0; i < KEY_COUNT; i++) begin
            k = (scan_key + i) % KEY_COUNT;
            if (key_count[k] != 0) begin
               take_oldest(k, frm, vel);
               scan_key = k;
               res.kind = KIND_NOTE;
               res.start_frame = frm;
               res.end_frame = limit_now;
               res.velocity = vel;
               res.pitch = PITCH_W'(k % PITCH_COUNT);
               res.channel = CHAN_W'(k / PITCH_COUNT);
               return 1'b1;
            end
         end
         scan_key = 0;
         res.kind = KIND_FLUSH_EMPTY;
         return 1'b1;
      end
      if (r.frame >= limit_now || r.status < STATUS_FIRST || msg == MSG_SYSTEM)
         return 1'b0;
      if (msg == MSG_NOTE_ON && r.data_two != 0) begin
         if (key_count[key] >= STARTS_PER_KEY) begin
            res.kind = KIND_DROPPED;
            res.start_frame = r.frame;
            res.velocity = r.data_two;
            res.pitch = r.data_one;
            res.channel = chan;
            return 1'b1;
         end
         slot = (key_head[key] + key_count[key]) % STARTS_PER_KEY;
         slot_frame[key * STARTS_PER_KEY + slot] = r.frame;
         slot_velocity[key * STARTS_PER_KEY + slot] = r.data_two;
         key_count[key]++;
         chan_open[chan]++;
         open_starts++;
         return 1'b0;
      end
      if (msg == MSG_NOTE_OFF || msg == MSG_NOTE_ON) begin
         if (key_count[key] == 0)
            return 1'b0;
         take_oldest(key, frm, vel);
         res.kind = KIND_NOTE;
         res.start_frame = frm;
         res.end_frame = r.frame;
         res.velocity = vel;
         res.pitch = r.data_one;
         res.channel = chan;
         return 1'b1;
      end
      if ((msg == MSG_PITCH_BEND || (msg == MSG_CONTROL && r.data_one == CC_BRIGHTNESS) ||
           msg == MSG_CHAN_PRESSURE) && chan_open[chan] != 0) begin
         res.kind = KIND_EXPR;
         res.start_frame = r.frame;
         res.channel = chan;
         res.expr_status = r.status;
         res.expr_data_one = r.data_one;
         res.expr_data_two = r.data_two;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // leaves tvalid high after the handshake; anything that waits lowers it first
   task automatic send_word(input request_type r);
      result_type res;
      int         gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.data_two, r.data_one, r.status, r.frame};
      req_tuser  <= r.flush;
      do @(posedge clock); while (!req_tready);
      if (pair_event(r, res))
         awaited_results.insert(awaited_results.size(), res);
      sent_items++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_frame_limit(input logic [FRAME_W-1:0] value);
      wait_drained();
      // let a word with no result finish before touching the register
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_now = value;
   endtask

   function automatic string describe(input result_type r);
      return $sformatf("kind %0d start %h end %h vel %0d pitch %0d chan %0d expr %h %0d %0d",
                       r.kind, r.start_frame, r.end_frame, r.velocity, r.pitch, r.channel,
                       r.expr_status, r.expr_data_one, r.expr_data_two);
   endfunction

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind          = kind_type'(rsp_tuser);
         got.start_frame   = rsp_tdata[31:0];
         got.end_frame     = rsp_tdata[63:32];
         got.velocity      = rsp_tdata[70:64];
         got.pitch         = rsp_tdata[77:71];
         got.channel       = rsp_tdata[81:78];
         got.expr_status   = rsp_tdata[89:82];
         got.expr_data_one = rsp_tdata[96:90];
         got.expr_data_two = rsp_tdata[103:97];
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word at cycle %0d: %s", cycle_count, describe(got));
         end else begin
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.start_frame !== want.start_frame ||
                got.end_frame !== want.end_frame || got.velocity !== want.velocity ||
                got.pitch !== want.pitch || got.channel !== want.channel ||
                got.expr_status !== want.expr_status ||
                got.expr_data_one !== want.expr_data_one ||
                got.expr_data_two !== want.expr_data_two) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch at cycle %0d", cycle_count);
                  $display("  expected %s", describe(want));
                  $display("  actual   %s", describe(got));
               end
            end
         end
      end
   end

   task automatic test_directed_cases();
      int n;
      send_word(midi_word(32'd0, {MSG_NOTE_ON, 4'h0}, 7'd0, 7'd127));
      send_word(midi_word(32'd5, {MSG_NOTE_OFF, 4'h0}, 7'd0, 7'd0));
      send_word(midi_word(32'hFFFF_FFFE, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd1));
      // note-on at zero velocity closes the note
      send_word(midi_word(32'hFFFF_FFFE, {MSG_NOTE_ON, 4'hF}, 7'd127, 7'd0));
      send_word(midi_word(32'd7, {MSG_NOTE_OFF, 4'h3}, 7'd60, 7'd64));
      send_word(midi_word(32'hFFFF_FFFF, {MSG_NOTE_ON, 4'h1}, 7'd10, 7'd100));
      send_word(midi_word(32'd8, 8'h7F, 7'd127, 7'd127));
      send_word(midi_word(32'd9, {MSG_SYSTEM, 4'h0}, 7'd1, 7'd2));
      send_word(midi_word(32'd9, {MSG_SYSTEM, 4'hF}, 7'd127, 7'd127));
      // expression on a silent channel is dropped
      send_word(midi_word(32'd10, {MSG_PITCH_BEND, 4'h2}, 7'd0, 7'd64));
      send_word(midi_word(32'd11, {MSG_NOTE_ON, 4'h2}, 7'd64, 7'd90));
      send_word(midi_word(32'd12, {MSG_PITCH_BEND, 4'h2}, 7'd127, 7'd127));
      send_word(midi_word(32'd13, {MSG_CONTROL, 4'h2}, CC_BRIGHTNESS, 7'd0));
      send_word(midi_word(32'd14, {MSG_CONTROL, 4'h2}, 7'd73, 7'd5));
      send_word(midi_word(32'd15, {MSG_CHAN_PRESSURE, 4'h2}, 7'd33, 7'd44));
      send_word(midi_word(32'd16, {MSG_POLY_PRESSURE, 4'h2}, 7'd64, 7'd9));
      send_word(midi_word(32'd17, {MSG_PROGRAM, 4'h2}, 7'd5, 7'd0));
      // fill the key queue, then overflow it
      for (n = 0; n < 4; n++)
         send_word(midi_word(32'd20 + n, {MSG_NOTE_ON, 4'h2}, 7'd64, 7'(10 + n)));
      // out of order frame is taken as it comes
      send_word(midi_word(32'd3, {MSG_NOTE_OFF, 4'h2}, 7'd64, 7'd0));
      for (n = 0; n < 4; n++)
         send_word(flush_word());
   endtask

   task automatic test_frame_limit_extremes();
      set_frame_limit(32'd1);
      send_word(midi_word(32'd0, {MSG_NOTE_ON, 4'h5}, 7'd0, 7'd1));
      send_word(midi_word(32'd1, {MSG_NOTE_OFF, 4'h5}, 7'd0, 7'd0));
      send_word(midi_word(32'd0, {MSG_NOTE_ON, 4'h5}, 7'd1, 7'd2));
      set_frame_limit(32'd0);
      send_word(midi_word(32'd0, {MSG_NOTE_ON, 4'h6}, 7'd3, 7'd4));
      send_word(midi_word(32'd0, {MSG_NOTE_OFF, 4'h5}, 7'd0, 7'd0));
      send_word(flush_word());
      send_word(flush_word());
      send_word(flush_word());
      set_frame_limit(32'h8000_0000);
      send_word(midi_word(32'h7FFF_FFFF, {MSG_NOTE_ON, 4'h7}, 7'd100, 7'd50));
      send_word(midi_word(32'h8000_0000, {MSG_NOTE_OFF, 4'h7}, 7'd100, 7'd0));
      send_word(flush_word());
      set_frame_limit(32'hFFFF_FFFF);
   endtask

   // stall the sink while pairs keep arriving, so the engine backs up its input
   task automatic test_output_backpressure();
      int n;
      wait_drained();
      sink_hold_cycles = 300;
      for (n = 0; n < 12; n++) begin
         send_word(midi_word(32'd100 + 2 * n, {MSG_NOTE_ON, 4'h9}, 7'(n), 7'(n + 1)));
         send_word(midi_word(32'd101 + 2 * n, {MSG_NOTE_OFF, 4'h9}, 7'(n), 7'd0));
      end
      wait_drained();
   endtask

   task automatic test_random_traffic(input int target);
      int                 phase;
      int                 n;
      int                 roll;
      int unsigned        base;
      int unsigned        span;
      longint unsigned    frame_now;
      logic [CHAN_W-1:0]  chans [2];
      logic [DATA_W-1:0]  pitches [3];
      logic [CHAN_W-1:0]  ch;
      logic [DATA_W-1:0]  d1;
      logic [3:0]         msg;
      phase = 0;
      sent_items = 0;
      while (sent_items < target) begin
         base = $urandom_range(0, 32'hF000_0000);
         span = $urandom_range(20000, 200000);
         set_frame_limit((phase % 4 == 0) ? 32'hFFFF_FFFF : base + span);
         // one phase runs flat out on both sides
         send_idle_pct = (phase == 2) ? 0 : 17;
         sink_idle_pct = (phase == 2) ? 0 : 17;
         chans[0] = CHAN_W'($urandom_range(15));
         chans[1] = CHAN_W'($urandom_range(15));
         for (n = 0; n < 3; n++)
            pitches[n] = DATA_W'($urandom_range(127));
         frame_now = base;
         for (n = 0; n < 40; n++) begin
            frame_now += $urandom_range(0, 3000);
            if ($urandom_range(99) < 5 && frame_now >= base + 2000)
               frame_now -= $urandom_range(1, 2000);
            ch = chans[$urandom_range(1)];
            d1 = pitches[$urandom_range(2)];
            roll = $urandom_range(99);
            if (roll < 40) begin
               send_word(midi_word(frame_now[31:0], {MSG_NOTE_ON, ch}, d1,
                                   DATA_W'($urandom_range(1, 127))));
            end else if (roll < 65) begin
               if ($urandom_range(1))
                  send_word(midi_word(frame_now[31:0], {MSG_NOTE_OFF, ch}, d1,
                                      DATA_W'($urandom_range(127))));
               else
                  send_word(midi_word(frame_now[31:0], {MSG_NOTE_ON, ch}, d1, 7'd0));
            end else if (roll < 80) begin
               case ($urandom_range(2))
                  0: msg = MSG_PITCH_BEND;
                  1: msg = MSG_CONTROL;
                  default: msg = MSG_CHAN_PRESSURE;
               endcase
               if ($urandom_range(3) == 0)
                  ch = CHAN_W'($urandom_range(15));
               d1 = (msg == MSG_CONTROL && $urandom_range(3) != 0) ? CC_BRIGHTNESS
                                                                   : 7'($urandom_range(127));
               send_word(midi_word(frame_now[31:0], {msg, ch}, d1,
                                   DATA_W'($urandom_range(127))));
            end else if (roll < 94) begin
               send_word(midi_word($urandom_range(1) ? $urandom : frame_now[31:0],
                                   STATUS_W'($urandom_range(255)),
                                   DATA_W'($urandom_range(127)),
                                   DATA_W'($urandom_range(127))));
            end else begin
               send_word(flush_word());
            end
         end
         // sometimes close every open note, ending on an empty flush
         if ($urandom_range(1)) begin
            while (open_starts != 0)
               send_word(flush_word());
            send_word(flush_word());
         end
         phase++;
      end
      send_idle_pct = 17;
      sink_idle_pct = 17;
   endtask

   initial begin
      for (int i = 0; i < KEY_COUNT; i++) begin
         key_head[i] = 0;
         key_count[i] = 0;
      end
      for (int i = 0; i < CHANNEL_COUNT; i++)
         chan_open[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // hold off until the metadata clearing pass is done
      do @(posedge clock); while (!req_tready);
      test_directed_cases();
      test_frame_limit_extremes();
      test_output_backpressure();
      test_random_traffic(390);
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
sv/npe_pkg.sv
sv/npe_ram.sv
sv/npe_seq.sv
sv/npe_rsp_stage.sv
sv/midi_note_pairing_engine_unit.sv
sv/npe_checker.sv
verif/tb.sv
